FILE: rtl/ste_pkg.sv
// ----------------------------------------------------------------------------
// ste_pkg
// Types and constants shared by the segment time estimator and its
// bit-serial arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ste_pkg;

    localparam int unsigned AluW  = 84;   // widest product: 42 x 41 bits
    localparam int unsigned OpbW  = 42;

    // register indexes on the APB port (byte address / 4)
    localparam logic [1:0] REG_MAX_VELOCITY     = 2'd0;
    localparam logic [1:0] REG_MAX_ACCELERATION = 2'd1;
    localparam logic [1:0] REG_SHAPE_CONSTANT   = 2'd2;

    localparam logic [15:0] VEL_RESET   = 16'd512;
    localparam logic [15:0] ACC_RESET   = 16'd512;
    localparam logic [15:0] SHAPE_RESET = 16'd1664;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_DIV,
        ALU_SQRT
    } alu_op_t;

    typedef struct packed {
        logic            start;
        alu_op_t         op;
        logic [AluW-1:0] opa;
        logic [OpbW-1:0] opb;
    } alu_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQRT,
        ST_DIVU,
        ST_TMUL,
        ST_TDIV,
        ST_SQR,
        ST_KMUL,
        ST_KDIV,
        ST_FMUL,
        ST_TIME,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/ste_alu.sv
// ----------------------------------------------------------------------------
// ste_alu
// Bit-serial shared unit: shift-add multiply (one multiplier bit a cycle),
// restoring divide (48-bit numerator, 16-bit divisor) and digit-by-digit
// square root (72-bit radicand). done pulses for one cycle with the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ste_alu
    import ste_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire alu_req_t        req,
    output logic                 done,
    output logic [AluW-1:0]      result
);

    logic            busy_reg;
    logic            done_reg;
    alu_op_t         op_reg;
    logic [AluW-1:0] acc_reg;
    logic [AluW-1:0] x_reg;
    logic [OpbW-1:0] y_reg;
    logic [37:0]     rem_reg;
    logic [5:0]      cnt_reg;

    logic [16:0] div_r2;
    logic        div_ge;
    logic [37:0] sq_r2;
    logic [37:0] sq_trial;
    logic        sq_ge;

    always_comb begin
        div_r2   = {rem_reg[15:0], x_reg[47]};
        div_ge   = div_r2 >= {1'b0, y_reg[15:0]};
        sq_r2    = {rem_reg[35:0], x_reg[71:70]};
        sq_trial = {acc_reg[35:0], 2'b01};
        sq_ge    = sq_r2 >= sq_trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                acc_reg  <= '0;
                rem_reg  <= '0;
                x_reg    <= req.opa;
                y_reg    <= req.opb;
                cnt_reg  <= (req.op == ALU_DIV) ? 6'd47 : 6'd35;
            end else if (busy_reg) begin
                unique case (op_reg)
                    ALU_MUL: begin
                        if (y_reg == '0) begin
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end else begin
                            if (y_reg[0])
                                acc_reg <= acc_reg + x_reg;
                            x_reg <= {x_reg[AluW-2:0], 1'b0};
                            y_reg <= {1'b0, y_reg[OpbW-1:1]};
                        end
                    end
                    ALU_DIV: begin
                        rem_reg <= {21'd0, div_ge ? (div_r2 - {1'b0, y_reg[15:0]}) : div_r2};
                        x_reg   <= {x_reg[AluW-2:0], div_ge};
                        cnt_reg <= cnt_reg - 6'd1;
                        if (cnt_reg == '0) begin
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end
                    end
                    ALU_SQRT: begin
                        rem_reg <= sq_ge ? (sq_r2 - sq_trial) : sq_r2;
                        acc_reg <= {acc_reg[AluW-2:0], sq_ge};
                        x_reg   <= {x_reg[AluW-3:0], 2'b00};
                        cnt_reg <= cnt_reg - 6'd1;
                        if (cnt_reg == '0) begin
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end
                    end
                    default: busy_reg <= 1'b0;
                endcase
            end
        end
    end

    always_comb begin
        unique case (op_reg)
            ALU_DIV:  result = {36'd0, x_reg[47:0]};
            ALU_SQRT: result = {48'd0, acc_reg[35:0]};
            default:  result = acc_reg;
        endcase
    end

    assign done = done_reg;

endmodule

`default_nettype wire

FILE: rtl/segment_time_estimator.sv
// A waypoint that gives no result is taken in the idle state. A segment runs
// from transfer to result through the bit-serial shared unit (one multiplier
// bit, quotient bit or root digit per cycle); the exponential series dominates.
// One waypoint at a time.
// Reset (aresetn low, synchronous): registers return to defaults, previous
// waypoint cleared, no result pending.
// ----------------------------------------------------------------------------
// segment_time_estimator
// Distance between successive waypoints, then t = u*(1 + c*v/a*exp(-u)),
// u = 2d/v, in fixed point, with a saturating Q16.16 result.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_time_estimator
    import ste_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // waypoints
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,   // pos_x, pos_y, pos_z
    input  wire logic        s_tuser,   // path_start
    // segment times
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // segment_time
    output logic             m_tuser    // saturated
);

    state_t state_reg, state_next;
    logic        pend_reg;
    logic [3:0]  cnt_reg;
    logic [15:0] vmax_reg, amax_reg, shape_reg;
    logic [31:0] prev_reg [3];
    logic        have_prev_reg;
    logic [31:0] ad_reg [3];
    logic [65:0] s_reg;
    logic [32:0] d_reg;
    logic [41:0] u_reg;
    logic [32:0] term_reg;
    logic [33:0] sum_reg;
    logic [31:0] e_reg;
    logic [40:0] k_reg;
    logic [31:0] time_reg;
    logic        sat_reg;

    alu_req_t        req;
    logic            alu_done;
    logic [AluW-1:0] alu_res;
    logic            step_done;
    logic            in_fire;
    logic            cfg_wr;
    logic [15:0]     v_eff, a_eff;
    logic [31:0]     ad_now [3];
    logic [31:0]     ad_sel;
    logic [32:0]     quot;
    logic [33:0]     sum_new;
    logic [41:0]     u_new;
    logic [67:0]     tw;

    ste_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .done    (alu_done),
        .result  (alu_res)
    );

    assign in_fire   = s_tvalid && s_tready;
    assign step_done = pend_reg && alu_done;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign v_eff     = (vmax_reg == '0) ? 16'd1 : vmax_reg;
    assign a_eff     = (amax_reg == '0) ? 16'd1 : amax_reg;
    assign quot      = alu_res[32:0];
    assign u_new     = alu_res[41:0];
    assign tw        = alu_res[83:16];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [32:0] diff;
            diff = {s_tdata[32*i+31], s_tdata[32*i +: 32]} - {prev_reg[i][31], prev_reg[i]};
            ad_now[i] = diff[32] ? 32'(-diff) : diff[31:0];
        end
    end

    always_comb begin
        unique case (cnt_reg[1:0])
            2'd1:    ad_sel = ad_reg[1];
            2'd2:    ad_sel = ad_reg[2];
            default: ad_sel = ad_reg[0];
        endcase
    end

    // alternating Taylor term: odd terms subtract, floor at zero
    always_comb begin
        if (cnt_reg[0])
            sum_new = (sum_reg >= {1'b0, quot}) ? (sum_reg - {1'b0, quot}) : '0;
        else
            sum_new = sum_reg + {1'b0, quot};
    end

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vmax_reg  <= VEL_RESET;
            amax_reg  <= ACC_RESET;
            shape_reg <= SHAPE_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_MAX_VELOCITY:     vmax_reg  <= pwdata[15:0];
                REG_MAX_ACCELERATION: amax_reg  <= pwdata[15:0];
                REG_SHAPE_CONSTANT:   shape_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MAX_VELOCITY:     prdata = {16'd0, vmax_reg};
            REG_MAX_ACCELERATION: prdata = {16'd0, amax_reg};
            REG_SHAPE_CONSTANT:   prdata = {16'd0, shape_reg};
            default:              prdata = '0;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_fire && !s_tuser && have_prev_reg)
                    state_next = ST_SQ;
            ST_SQ:
                if (step_done && cnt_reg == 4'd2)
                    state_next = ST_SQRT;
            ST_SQRT:
                if (step_done)
                    state_next = ST_DIVU;
            ST_DIVU:
                if (step_done) begin
                    if (u_new == '0)
                        state_next = ST_OUT;
                    else if (u_new[41:21] != '0)
                        state_next = ST_KMUL;
                    else
                        state_next = ST_TMUL;
                end
            ST_TMUL:
                if (step_done)
                    state_next = ST_TDIV;
            ST_TDIV:
                if (step_done)
                    state_next = (cnt_reg == 4'd12) ? ST_SQR : ST_TMUL;
            ST_SQR:
                if (step_done && cnt_reg == 4'd5)
                    state_next = ST_KMUL;
            ST_KMUL:
                if (step_done)
                    state_next = ST_KDIV;
            ST_KDIV:
                if (step_done)
                    state_next = ST_FMUL;
            ST_FMUL:
                if (step_done)
                    state_next = ST_TIME;
            ST_TIME:
                if (step_done)
                    state_next = ST_OUT;
            ST_OUT:
                if (m_tready)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and unit requests
    always_comb begin
        req.start = 1'b0;
        req.op    = ALU_MUL;
        req.opa   = '0;
        req.opb   = '0;
        s_tready  = 1'b0;
        m_tvalid  = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_OUT:  m_tvalid = 1'b1;
            ST_SQ: begin
                req.opa = AluW'(ad_sel);
                req.opb = OpbW'(ad_sel);
            end
            ST_SQRT: begin
                req.op  = ALU_SQRT;
                req.opa = AluW'({6'd0, s_reg});
            end
            ST_DIVU: begin
                req.op  = ALU_DIV;
                req.opa = AluW'({d_reg, 9'd0});
                req.opb = OpbW'(v_eff);
            end
            ST_TMUL: begin
                req.opa = AluW'(term_reg);
                req.opb = OpbW'({u_reg[20:0], 10'd0});
            end
            ST_TDIV: begin
                req.op  = ALU_DIV;
                req.opa = AluW'(term_reg);
                req.opb = OpbW'(cnt_reg);
            end
            ST_SQR: begin
                req.opa = AluW'(e_reg);
                req.opb = OpbW'(e_reg);
            end
            ST_KMUL: begin
                req.opa = AluW'(shape_reg);
                req.opb = OpbW'(v_eff);
            end
            ST_KDIV: begin
                req.op  = ALU_DIV;
                req.opa = AluW'({k_reg[31:0], 8'd0});
                req.opb = OpbW'(a_eff);
            end
            ST_FMUL: begin
                req.opa = AluW'(k_reg);
                req.opb = OpbW'(e_reg);
            end
            ST_TIME: begin
                req.opa = AluW'(u_reg);
                req.opb = OpbW'(k_reg);
            end
            default: ;
        endcase
        if (state_reg != ST_IDLE && state_reg != ST_OUT)
            req.start = !pend_reg;
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            have_prev_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
                prev_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            if (req.start)
                pend_reg <= 1'b1;
            else if (alu_done)
                pend_reg <= 1'b0;
            if (in_fire) begin
                have_prev_reg <= 1'b1;
                for (int i = 0; i < 3; i++)
                    prev_reg[i] <= s_tdata[32*i +: 32];
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            for (int i = 0; i < 3; i++)
                ad_reg[i] <= ad_now[i];
            s_reg   <= '0;
            cnt_reg <= '0;
        end
        if (step_done) begin
            unique case (state_reg)
                ST_SQ: begin
                    s_reg   <= s_reg + alu_res[65:0];
                    cnt_reg <= cnt_reg + 4'd1;
                end
                ST_SQRT: d_reg <= alu_res[32:0];
                ST_DIVU: begin
                    u_reg    <= u_new;
                    e_reg    <= '0;
                    term_reg <= 33'h1_0000_0000;
                    sum_reg  <= 34'h1_0000_0000;
                    cnt_reg  <= 4'd1;
                    time_reg <= '0;
                    sat_reg  <= 1'b0;
                end
                ST_TMUL: term_reg <= alu_res[64:32];
                ST_TDIV: begin
                    term_reg <= quot;
                    sum_reg  <= sum_new;
                    if (cnt_reg == 4'd12) begin
                        e_reg   <= (sum_new[33:32] != '0) ? 32'hFFFF_FFFF : sum_new[31:0];
                        cnt_reg <= '0;
                    end else begin
                        cnt_reg <= cnt_reg + 4'd1;
                    end
                end
                ST_SQR: begin
                    e_reg   <= alu_res[63:32];
                    cnt_reg <= cnt_reg + 4'd1;
                end
                ST_KMUL: k_reg <= {9'd0, alu_res[31:0]};
                ST_KDIV: k_reg <= {1'b0, alu_res[39:0]};
                ST_FMUL: k_reg <= {1'b0, alu_res[71:32]} + 41'h1_0000;
                ST_TIME: begin
                    sat_reg  <= tw[67:32] != '0;
                    time_reg <= (tw[67:32] != '0) ? 32'hFFFF_FFFF : tw[31:0];
                end
                default: ;
            endcase
        end
    end

    assign m_tdata = time_reg;
    assign m_tuser = sat_reg;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while a result is pending");

    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == 32'hFFFF_FFFF))
        else $error("saturated result not clamped");

    a_done_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        alu_done |-> pend_reg)
        else $error("unit finished without a request");

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |=> pend_reg && !alu_done)
        else $error("unit request not tracked");

endmodule

`default_nettype wire

FILE: sim/segment_time_estimator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_time_estimator_tb
// Feeds waypoints over the stream port and compares every segment time with
// a bit-exact fixed-point predictor. Register settings are changed over APB
// between phases while the block is idle.
// ----------------------------------------------------------------------------

module segment_time_estimator_tb
    import ste_pkg::*;
();

    localparam int LATENCY = 1700;

    typedef struct {
        logic [31:0] x, y, z;
        logic        start;
        logic        chk;
        logic [31:0] t;
        logic        sat;
    } row_t;

    typedef struct {
        logic [31:0] t;
        logic        sat;
    } seg_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [95:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic m_tuser;

    segment_time_estimator uut (.*);

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #40_000_000;
        $display("[segment_time_estimator] ERROR");
        $finish;
    end

    // predictor state
    logic [15:0] vel_q = VEL_RESET, acc_q = ACC_RESET, shape_q = SHAPE_RESET;
    logic signed [31:0] last_pos [3] = '{0, 0, 0};
    logic have_last = 1'b0;

    seg_t times_due [$];
    int errors = 0;
    int send_idle = 0, recv_idle = 0;
    bit hold_recv = 0;

    function automatic logic [63:0] exp_neg_q32(logic [63:0] u);
        logic [63:0] w, term, sum;
        logic [127:0] p;
        if (u >= (64'd32 << 16)) return 0;
        w = u << 10;
        term = 64'd1 << 32;
        sum = term;
        for (int k = 1; k <= 12; k++) begin
            p = term * w;
            term = (p >> 32) / k;
            if (k % 2) sum = (sum >= term) ? sum - term : 0;
            else sum = sum + term;
        end
        if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
        for (int k = 0; k < 6; k++) begin
            p = sum * sum;
            sum = p >> 32;
        end
        return sum;
    endfunction

    // returns 1 when the waypoint closes a segment
    function automatic bit segment_time(logic [31:0] x, logic [31:0] y,
                                        logic [31:0] z, logic start,
                                        output seg_t r);
        logic signed [32:0] dv;
        logic [127:0] s, p;
        logic [63:0] d, cand, u, e, k, v, a, fac;
        logic signed [31:0] pos [3];
        bit emit;
        pos[0] = x; pos[1] = y; pos[2] = z;
        emit = !start && have_last;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            dv = 33'(pos[i]) - 33'(last_pos[i]);
            if (dv < 0) dv = -dv;
            s += 128'(dv) * 128'(dv);
            last_pos[i] = pos[i];
        end
        have_last = 1'b1;
        r.t = 0; r.sat = 0;
        if (!emit) return 0;
        v = (vel_q == 0) ? 1 : vel_q;
        a = (acc_q == 0) ? 1 : acc_q;
        d = 0;
        for (int b = 35; b >= 0; b--) begin
            cand = d | (64'd1 << b);
            if (128'(cand) * 128'(cand) <= s) d = cand;
        end
        u = (d * 512) / v;
        if (u == 0) return 1;
        e = exp_neg_q32(u);
        k = (64'(shape_q) * v * 256) / a;
        p = 128'(k) * 128'(e);
        fac = (64'd1 << 16) + 64'(p >> 32);
        p = (128'(u) * 128'(fac)) >> 16;
        if (p > 128'hFFFF_FFFF) begin
            r.t = 32'hFFFF_FFFF; r.sat = 1;
        end else begin
            r.t = p[31:0];
        end
        return 1;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic apb_write(logic [1:0] idx, logic [15:0] val);
        @(negedge aclk);
        psel = 1; penable = 0; pwrite = 1; paddr = {idx, 2'b00}; pwdata = 32'(val);
        @(negedge aclk);
        penable = 1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel = 0; penable = 0; pwrite = 0;
        case (idx)
            REG_MAX_VELOCITY:     vel_q = val;
            REG_MAX_ACCELERATION: acc_q = val;
            REG_SHAPE_CONSTANT:   shape_q = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        int n = 0;
        while (times_due.size() != 0 && n < 4_000_000) begin
            @(posedge aclk);
            n++;
        end
        repeat (LATENCY) @(posedge aclk);
        @(negedge aclk);
    endtask

    // one transfer on the waypoint port; prediction at acceptance
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic start, bit chk, logic [31:0] t, logic sat);
        seg_t r;
        while (send_idle > 0 && $urandom_range(99) < send_idle) @(negedge aclk);
        s_tvalid = 1; s_tdata = {z, y, x}; s_tuser = start;
        do @(posedge aclk); while (!s_tready);
        if (segment_time(x, y, z, start, r)) begin
            if (chk && (r.t !== t || r.sat !== sat))
                report("directed table", r.t, t);
            times_due.insert(times_due.size(), r);
        end
        @(negedge aclk);
        s_tvalid = 0;
    endtask

    // receiver
    initial begin
        forever begin
            @(negedge aclk);
            m_tready = !hold_recv && !(recv_idle > 0 && $urandom_range(99) < recv_idle);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (times_due.size() == 0) begin
                report("unexpected transfer", m_tdata, 0);
            end else begin
                seg_t want;
                want = times_due.pop_front();
                if (m_tdata !== want.t) report("segment_time", m_tdata, want.t);
                if (m_tuser !== want.sat)
                    report("saturated", 32'(m_tuser), 32'(want.sat));
            end
        end
    end

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
            default: return 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
        endcase
    endfunction

    row_t directed [] = '{
        // no previous waypoint: stored only
        '{32'h0001_0000, 0, 0, 0, 0, 0, 0},
        // zero distance
        '{32'h0001_0000, 0, 0, 0, 1, 0, 0},
        '{32'h0002_0000, 0, 0, 0, 0, 0, 0},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0, 0, 0},
        // extreme distance saturates
        '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 1, 32'hFFFF_FFFF, 1},
        '{32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0, 0},
        '{32'h0000_0001, 0, 0, 0, 0, 0, 0},
        '{32'h0000_0000, 0, 0, 0, 0, 0, 0},
        '{32'h0000_0000, 32'h0010_0000, 32'hFFFF_0000, 0, 0, 0, 0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0},
        '{32'h0004_0000, 32'h0003_0000, 0, 0, 0, 0, 0},
        '{32'h0040_0000, 32'hFFC0_0000, 32'h0020_0000, 0, 0, 0, 0}
    };

    task automatic random_burst(int n);
        for (int i = 0; i < n; i++) begin
            int mode = $urandom_range(2);
            send_point(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                       $urandom_range(9) == 0, 0, 0, 0);
        end
    endtask

    initial begin
        logic [15:0] settings [6][3] = '{
            '{16'd512, 16'd512, 16'd1664},
            '{16'hFFFF, 16'h0001, 16'hFFFF},
            '{16'h0001, 16'hFFFF, 16'h0000},
            '{16'h0000, 16'h0000, 16'h0100},
            '{16'h0100, 16'h0080, 16'h0200},
            '{16'h0400, 16'h0200, 16'h0680}
        };
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
        foreach (directed[i])
            send_point(directed[i].x, directed[i].y, directed[i].z, directed[i].start,
                       directed[i].chk, directed[i].t, directed[i].sat);
        drain();
        for (int ph = 1; ph < 6; ph++) begin
            apb_write(REG_MAX_VELOCITY, settings[ph][0]);
            apb_write(REG_MAX_ACCELERATION, settings[ph][1]);
            apb_write(REG_SHAPE_CONSTANT, settings[ph][2]);
            case (ph)
                1: begin send_idle = 34; recv_idle = 70; end
                3: begin send_idle = 70; recv_idle = 34; end
                5: begin send_idle = 0; recv_idle = 0; end
                default: ;
            endcase
            random_burst(150);
            if (ph == 2) begin
                // long receiver hold-off while waypoints keep coming
                fork
                    begin
                        hold_recv = 1;
                        repeat (8000) @(posedge aclk);
                        hold_recv = 0;
                    end
                    random_burst(20);
                join
            end
            // sender waits out every pending segment
            drain();
            random_burst(50);
            drain();
        end
        if (errors == 0) begin
            $display("[segment_time_estimator] OK");
        end else begin
            $display("[segment_time_estimator] ERROR");
        end
        $finish;
    end

endmodule
